/* design/assert_macros.svh */
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/conv3_pkg.sv */
// Types and constants of the 3x3 valid convolution stream block.
package conv3_pkg;

   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int MAX_DIM_DEF = 64;
   localparam int MIN_DIM     = 3;

   localparam int VALUE_W    = 16;
   localparam int DIM_W      = 7;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int PART_W     = PROD_W + 2;   // sum of three products
   localparam int RESULT_W   = PART_W + 2;   // sum of three partial sums
   localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
   localparam int LINE_W     = 2 * VALUE_W;
   localparam int WIDX_W     = $clog2(TAPS);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   typedef enum logic [0:0] {
      OP_WEIGHT = 1'b0,
      OP_PIXEL  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_ROWS = 1'b0,
      CSR_IMAGE_COLS = 1'b1
   } csr_type;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [TAPS-1:0][VALUE_W-1:0] taps_type;

   // Control that travels with an item through the dot product stages.
   typedef struct packed {
      logic vld;
      logic last;
   } tag_type;

endpackage

/* design/conv3_dot.sv */
// Pipelined 3x3 dot product: products, row sums, final sum.
module conv3_dot (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  conv3_pkg::tag_type                    in_tag,
   input  conv3_pkg::taps_type                   win,
   input  conv3_pkg::taps_type                   wts,
   output conv3_pkg::tag_type                    out_tag,
   output logic signed [conv3_pkg::RESULT_W-1:0] out_sum
);
   import conv3_pkg::*;

   logic signed [PROD_W-1:0]   prod_in  [TAPS];
   logic signed [PROD_W-1:0]   prod_ff  [TAPS];
   logic signed [PART_W-1:0]   part_in  [KERNEL_SIZE];
   logic signed [PART_W-1:0]   part_ff  [KERNEL_SIZE];
   logic signed [RESULT_W-1:0] sum_in;
   logic signed [RESULT_W-1:0] sum_ff;
   tag_type                    tag2_ff;
   tag_type                    tag3_ff;
   tag_type                    tag4_ff;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         prod_in[i] = $signed(win[i]) * $signed(wts[i]);
      end
   end

   always_comb begin
      for (int g = 0; g < KERNEL_SIZE; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            part_in[g] = part_in[g] + PART_W'(prod_ff[g * KERNEL_SIZE + k]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < KERNEL_SIZE; g++) begin
         sum_in = sum_in + RESULT_W'(part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (en) begin
         tag2_ff <= in_tag;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_tag = tag4_ff;
   assign out_sum = sum_ff;

endmodule

/* design/conv2d_3x3_valid_stream_top.sv */
// A pixel's result passes the stage 1 registers, dot stages 2 to 4 and the output queue.
// Throughput: one item (pixel or weight) per cycle; req_tready drops only while both output
// queue slots hold results. One line store read and one write per cycle, at different columns.
// Reset (synchronous, active high): clears pixel and weight counters, weights,
// window, line store valid bits and the output queue; both dimensions go to 64.
module conv2d_3x3_valid_stream_top #(
   parameter int MAX_DIM = conv3_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel / weight input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [conv3_pkg::VALUE_W-1:0]       req_tdata,   // [15:0] value
   input  logic [0:0]                          req_tuser,   // [0] op
   // convolution results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [conv3_pkg::OUT_DATA_W-1:0]    rsp_tdata,   // [35:0] result, rest zero
   output logic                                rsp_tlast,
   // register writes
   input  logic                                csr_we,
   input  conv3_pkg::csr_type                  csr_index,
   input  logic [conv3_pkg::DIM_W-1:0]         csr_wdata
);
   import conv3_pkg::*;

   localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW_MIN = $clog2(MAX_DIM + 1);
   localparam int CW     = (CW_MIN > DIM_W) ? CW_MIN : DIM_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [DIM_W-1:0] rows_ff;
   logic [DIM_W-1:0] cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_ROWS: rows_ff <= csr_wdata;
            CSR_IMAGE_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the dimensions into the legal range.
   logic [CW-1:0] rows_x;
   logic [CW-1:0] cols_x;
   logic [CW-1:0] rows_eff;
   logic [CW-1:0] cols_eff;

   always_comb begin
      rows_x = CW'(rows_ff);
      cols_x = CW'(cols_ff);
      if (rows_x < CW'(MIN_DIM)) begin
         rows_eff = CW'(MIN_DIM);
      end else if (rows_x > CW'(MAX_DIM)) begin
         rows_eff = CW'(MAX_DIM);
      end else begin
         rows_eff = rows_x;
      end
      if (cols_x < CW'(MIN_DIM)) begin
         cols_eff = CW'(MIN_DIM);
      end else if (cols_x > CW'(MAX_DIM)) begin
         cols_eff = CW'(MAX_DIM);
      end else begin
         cols_eff = cols_x;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: the whole pipe advances while the output queue
   // has a free slot, so ready never depends on rsp_tready.
   // ---------------------------------------------------------------
   logic [1:0] count_ff;
   logic       advance;
   logic       accept;
   logic       pix_accept;

   assign advance    = (count_ff != 2'd2);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign pix_accept = accept && (req_tuser == OP_PIXEL);

   // ---------------------------------------------------------------
   // Stage 0: pixel position, window-complete and frame-end decisions
   // ---------------------------------------------------------------
   logic [AW-1:0] pixel_row_ff;
   logic [AW-1:0] pixel_col_ff;
   logic [CW-1:0] col_nx;
   logic [CW-1:0] row_nx;
   logic          row_end;
   logic          frame_end;
   logic          emit;

   always_comb begin
      col_nx    = CW'(pixel_col_ff) + CW'(1);
      row_nx    = CW'(pixel_row_ff) + CW'(1);
      row_end   = (col_nx >= cols_eff);
      frame_end = row_end && (row_nx >= rows_eff);
      emit      = (CW'(pixel_row_ff) >= CW'(KERNEL_SIZE - 1))
               && (CW'(pixel_col_ff) >= CW'(KERNEL_SIZE - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_row_ff <= '0;
         pixel_col_ff <= '0;
      end else if (pix_accept) begin
         if (frame_end) begin
            pixel_row_ff <= '0;
            pixel_col_ff <= '0;
         end else if (row_end) begin
            pixel_row_ff <= row_nx[AW-1:0];
            pixel_col_ff <= '0;
         end else begin
            pixel_col_ff <= col_nx[AW-1:0];
         end
      end
   end

   // Stage 1 registers
   logic             s1_vld_ff;
   op_type           s1_op_ff;
   value_type        s1_value_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op_type'(req_tuser);
         s1_value_ff <= req_tdata;
         s1_addr_ff  <= pixel_col_ff;
         s1_emit_ff  <= emit;
         s1_last_ff  <= frame_end;
      end
   end

   // ---------------------------------------------------------------
   // Line store: one entry per column holds {row r-2, row r-1}.
   // Read at accept, written back at stage 1. Consecutive pixels are
   // always at different columns, so no forwarding is needed.
   // ---------------------------------------------------------------
   logic [LINE_W-1:0]  line_store_ff [MAX_DIM];
   logic [LINE_W-1:0]  line_rd_ff;
   logic [MAX_DIM-1:0] row_valid_ff;
   logic               line_wr;
   value_type          top;
   value_type          mid;

   assign line_wr = advance && s1_vld_ff && (s1_op_ff == OP_PIXEL);

   always_comb begin
      if (row_valid_ff[s1_addr_ff]) begin
         top = line_rd_ff[LINE_W-1:VALUE_W];
         mid = line_rd_ff[VALUE_W-1:0];
      end else begin
         top = '0;
         mid = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         line_rd_ff <= line_store_ff[pixel_col_ff];
      end
      if (line_wr) begin
         line_store_ff[s1_addr_ff] <= {mid, s1_value_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (line_wr) begin
         row_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: weight load, window shift
   // ---------------------------------------------------------------
   taps_type          weights_ff;
   logic [WIDX_W-1:0] widx_ff;
   taps_type          window_ff;
   taps_type          window_in;
   logic              wt_wr;
   tag_type           s1_tag;

   assign wt_wr = advance && s1_vld_ff && (s1_op_ff == OP_WEIGHT);

   // Shift each window row left, new column enters on the right.
   always_comb begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n < KERNEL_SIZE - 1; n++) begin
            window_in[m * KERNEL_SIZE + n] = window_ff[m * KERNEL_SIZE + n + 1];
         end
      end
      window_in[KERNEL_SIZE - 1]     = top;
      window_in[2 * KERNEL_SIZE - 1] = mid;
      window_in[3 * KERNEL_SIZE - 1] = s1_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '0;
         widx_ff    <= '0;
         window_ff  <= '0;
      end else begin
         if (wt_wr) begin
            weights_ff[widx_ff] <= s1_value_ff;
            widx_ff <= (widx_ff == WIDX_W'(TAPS - 1)) ? '0 : widx_ff + WIDX_W'(1);
         end
         if (line_wr) begin
            window_ff <= window_in;
         end
      end
   end

   assign s1_tag.vld  = line_wr && s1_emit_ff;
   assign s1_tag.last = s1_last_ff;

   // ---------------------------------------------------------------
   // Stages 2 to 4: dot product
   // ---------------------------------------------------------------
   tag_type                    dot_tag;
   logic signed [RESULT_W-1:0] dot_sum;

   conv3_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .in_tag  (s1_tag),
      .win     (window_in),
      .wts     (weights_ff),
      .out_tag (dot_tag),
      .out_sum (dot_sum)
   );

   // ---------------------------------------------------------------
   // Output queue: two slots, so the pipe keeps moving while a result
   // waits for its transfer.
   // ---------------------------------------------------------------
   logic [RESULT_W:0] out_q_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic              push;
   logic              pop;
   logic [RESULT_W:0] head;

   assign push = advance && dot_tag.vld;
   assign pop  = rsp_tvalid && rsp_tready;
   assign head = out_q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_q_ff[wr_ptr_ff] <= {dot_tag.last, dot_sum};
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = OUT_DATA_W'(head[RESULT_W-1:0]);
   assign rsp_tlast  = head[RESULT_W];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`include "assert_macros.svh"

   `ASSERT_CLK(a_line_no_overlap, (pix_accept && line_wr) |-> (pixel_col_ff != s1_addr_ff), "line store read and write hit the same column")
   `ASSERT_CLK(a_queue_bound, count_ff <= 2'd2, "output queue overflow")
   `ASSERT_CLK(a_widx_range, widx_ff < WIDX_W'(TAPS), "weight index out of range")
   `ASSERT_NEXT(a_frame_wrap, pix_accept && frame_end, (pixel_row_ff == '0) && (pixel_col_ff == '0), "counters did not wrap at frame end")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the 3x3 valid convolution stream block.
`timescale 1ns / 1ps

module testbench;
   import conv3_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_ITEMS = 2000;
   localparam int SETTLE_CYCLES = 12;    // pipeline is 5 deep; leave margin
   localparam int IDLE_LIMIT   = 2000;   // cycles without any transfer
   localparam int FRAME_CAP    = 500;    // cap on pixels sent toward one frame end
   localparam int LINE_DEPTH   = MAX_DIM_DEF;

   typedef logic [DIM_W-1:0] dim_word;

   // One predicted convolution output.
   typedef struct {
      logic [RESULT_W-1:0] sum;
      logic                is_last;
   } conv_out_t;

   // Tracks the expected window sums and compares them with the block output.
   class conv3_scoreboard;
      value_type kernel[TAPS];
      int        tap_next;
      value_type line_top[LINE_DEPTH];
      value_type line_mid[LINE_DEPTH];
      value_type win[KERNEL_SIZE][KERNEL_SIZE];
      int        row_cnt;
      int        col_cnt;
      dim_word   rows_reg;
      dim_word   cols_reg;
      conv_out_t pending_sums[$];
      int        errors;

      function new();
         foreach (kernel[i]) kernel[i] = '0;
         foreach (line_top[i]) begin
            line_top[i] = '0;
            line_mid[i] = '0;
         end
         foreach (win[m, n]) win[m][n] = '0;
         tap_next = 0;
         row_cnt  = 0;
         col_cnt  = 0;
         rows_reg = DIM_RESET;
         cols_reg = DIM_RESET;
         errors   = 0;
      endfunction

      function int clamp_dim(dim_word v);
         if (v < MIN_DIM) return MIN_DIM;
         if (v > LINE_DEPTH) return LINE_DEPTH;
         return int'(v);
      endfunction

      function void write_dim(csr_type idx, dim_word v);
         if (idx == CSR_IMAGE_ROWS) rows_reg = v;
         else cols_reg = v;
      endfunction

      function bit at_frame_start();
         return row_cnt == 0 && col_cnt == 0;
      endfunction

      function int pending_count();
         return pending_sums.size();
      endfunction

      // Note one accepted input transfer and queue the sum it completes, if any.
      function void take_item(op_type op, value_type v);
         int        nrows;
         int        ncols;
         value_type top;
         value_type mid;
         bit        row_end;
         bit        frame_end;
         longint    acc;
         conv_out_t s;

         if (op == OP_WEIGHT) begin
            kernel[tap_next] = v;
            tap_next = (tap_next == TAPS - 1) ? 0 : tap_next + 1;
            return;
         end

         nrows = clamp_dim(rows_reg);
         ncols = clamp_dim(cols_reg);
         top   = line_top[col_cnt];
         mid   = line_mid[col_cnt];

         // slide the window left, oldest row on top
         for (int m = 0; m < KERNEL_SIZE; m++)
            for (int n = 0; n < KERNEL_SIZE - 1; n++)
               win[m][n] = win[m][n + 1];
         win[0][KERNEL_SIZE - 1] = top;
         win[1][KERNEL_SIZE - 1] = mid;
         win[2][KERNEL_SIZE - 1] = v;

         line_top[col_cnt] = mid;
         line_mid[col_cnt] = v;

         row_end   = (col_cnt + 1 >= ncols);
         frame_end = row_end && (row_cnt + 1 >= nrows);

         if (row_cnt >= 2 && col_cnt >= 2) begin
            acc = 0;
            for (int m = 0; m < KERNEL_SIZE; m++)
               for (int n = 0; n < KERNEL_SIZE; n++)
                  acc += longint'(win[m][n]) * longint'(kernel[m * KERNEL_SIZE + n]);
            s.sum     = acc[RESULT_W-1:0];
            s.is_last = frame_end;
            pending_sums.push_back(s);
         end

         if (frame_end) begin
            row_cnt = 0;
            col_cnt = 0;
         end else if (row_end) begin
            row_cnt++;
            col_cnt = 0;
         end else begin
            col_cnt++;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Compare one output transfer with the oldest expected sum.
      task check_sum(logic [OUT_DATA_W-1:0] tdata, logic tlast);
         conv_out_t s;
         if (pending_sums.size() == 0) begin
            report($sformatf("unexpected output data=%h last=%b", tdata, tlast));
            return;
         end
         s = pending_sums.pop_front();
         if (tdata[RESULT_W-1:0] !== s.sum)
            report($sformatf("sum %h, expected %h", tdata[RESULT_W-1:0], s.sum));
         if (tdata[OUT_DATA_W-1:RESULT_W] !== '0)
            report($sformatf("padding bits %h not zero", tdata[OUT_DATA_W-1:RESULT_W]));
         if (tlast !== s.is_last)
            report($sformatf("last %b, expected %b", tlast, s.is_last));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;    // [15:0] value
   logic [0:0]            req_tuser;    // [0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;    // [35:0] result, [39:36] zero
   logic                  rsp_tlast;
   logic                  csr_we;
   csr_type               csr_index;
   logic [DIM_W-1:0]      csr_wdata;

   conv3_scoreboard board = new();
   int burst_left;
   int items_sent;
   int idle_cycles;

   conv2d_3x3_valid_stream_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Bias toward the extreme codes so that full-scale products show up often.
   function value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'sh8000;
      if (r < 20) return 16'sh7FFF;
      if (r < 25) return 16'sh0000;
      if (r < 30) return 16'shFFFF;
      return value_type'($urandom);
   endfunction

   // Mostly small images so that frames close often; now and then the
   // largest size, the smallest, or a value that must saturate.
   function dim_word pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return dim_word'($urandom_range(3, 8));
      if (r < 70) return dim_word'($urandom_range(9, 20));
      if (r < 78) return dim_word'(64);
      if (r < 84) return dim_word'(3);
      if (r < 90) return dim_word'($urandom_range(0, 2));
      if (r < 95) return dim_word'($urandom_range(65, 127));
      return dim_word'($urandom_range(21, 63));
   endfunction

   // Drive one item from a falling edge and hold it until the transfer.
   // The sender runs in bursts; between bursts valid drops for a random gap,
   // and about a quarter of the bursts follow the previous one back to back.
   task send_item(op_type op, value_type v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = v;
      do @(posedge clock); while (!req_tready);
      board.take_item(op, v);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every expected output has arrived, then let
   // the pipeline settle so that items without an output are done too.
   task drain_pipeline();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (board.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; the block is idle whenever this is called.
   task write_dim(csr_type idx, dim_word v);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      board.write_dim(idx, v);
   endtask

   task load_kernel();
      repeat (TAPS) send_item(OP_WEIGHT, pick_value());
   endtask

   // Send pixels, with an occasional stray weight mixed in. Either a fixed
   // count, or until the current frame closes (capped for big images).
   task run_pixels(int count, bit to_frame_end);
      int  n;
      bit  done;
      n = 0;
      do begin
         if ($urandom_range(0, 32) == 0) send_item(OP_WEIGHT, pick_value());
         send_item(OP_PIXEL, pick_value());
         n++;
         done = to_frame_end ? (board.at_frame_start() || n >= FRAME_CAP) : (n >= count);
      end while (!done);
   endtask

   // Output side: stall on a pattern that changes mode at random times
   // (never stall, coin flip, rare long stalls, mostly ready).
   initial begin
      int stall_left;
      int mode;
      int mode_cycles;
      rsp_tready  = 1'b0;
      stall_left  = 0;
      mode        = 0;
      mode_cycles = 0;
      forever begin
         @(negedge clock);
         if (mode_cycles == 0) begin
            mode        = $urandom_range(0, 3);
            mode_cycles = $urandom_range(50, 300);
         end
         mode_cycles--;
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: begin
                  if ($urandom_range(0, 9) == 0) begin
                     rsp_tready = 1'b0;
                     stall_left = $urandom_range(1, 30);
                  end else begin
                     rsp_tready = 1'b1;
                  end
               end
               default: rsp_tready = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Check every output transfer at the rising edge where it happens.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_sum(rsp_tdata, rsp_tlast);
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_WEIGHT;
      csr_we      = 1'b0;
      csr_index   = CSR_IMAGE_ROWS;
      csr_wdata   = '0;
      burst_left  = 0;
      items_sent  = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Smallest image with every weight and pixel at the most negative
      // code: the single output is the largest positive sum and closes
      // the frame.
      write_dim(CSR_IMAGE_ROWS, dim_word'(3));
      write_dim(CSR_IMAGE_COLS, dim_word'(3));
      repeat (TAPS) send_item(OP_WEIGHT, 16'sh8000);
      repeat (TAPS) send_item(OP_PIXEL, 16'sh8000);
      // Same image again with the most positive pixels, for the most
      // negative sum.
      repeat (TAPS) send_item(OP_PIXEL, 16'sh7FFF);

      // Tallest image with the narrowest rows, one full frame.
      drain_pipeline();
      write_dim(CSR_IMAGE_ROWS, dim_word'(64));
      write_dim(CSR_IMAGE_COLS, dim_word'(3));
      load_kernel();
      run_pixels(0, 1'b1);

      // Out-of-range codes: rows saturate up to 3, columns down to 64.
      drain_pipeline();
      write_dim(CSR_IMAGE_ROWS, dim_word'(0));
      write_dim(CSR_IMAGE_COLS, dim_word'(127));
      run_pixels(0, 1'b1);

      // Shrink the image mid-frame: first the row count to the current
      // row index, then the column count below the current column.
      drain_pipeline();
      write_dim(CSR_IMAGE_ROWS, dim_word'(9));
      write_dim(CSR_IMAGE_COLS, dim_word'(5));
      run_pixels(22, 1'b0);
      drain_pipeline();
      write_dim(CSR_IMAGE_ROWS, dim_word'(4));
      run_pixels(2, 1'b0);
      drain_pipeline();
      write_dim(CSR_IMAGE_COLS, dim_word'(3));
      run_pixels(0, 1'b1);

      // Largest image; send part of a frame so the next phase may change
      // dimensions in the middle of it.
      drain_pipeline();
      write_dim(CSR_IMAGE_ROWS, dim_word'(64));
      write_dim(CSR_IMAGE_COLS, dim_word'(64));
      run_pixels(300, 1'b0);

      // Random phases: drain, maybe reconfigure, maybe reload the kernel,
      // then either finish the frame or stop part way through it.
      while (items_sent < RANDOM_ITEMS) begin
         drain_pipeline();
         case ($urandom_range(0, 3))
            1: write_dim(CSR_IMAGE_ROWS, pick_dim());
            2: write_dim(CSR_IMAGE_COLS, pick_dim());
            3: begin
               write_dim(CSR_IMAGE_ROWS, pick_dim());
               write_dim(CSR_IMAGE_COLS, pick_dim());
            end
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0) load_kernel();
         if ($urandom_range(0, 9) < 6) run_pixels(0, 1'b1);
         else run_pixels($urandom_range(1, 200), 1'b0);
      end

      drain_pipeline();
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/conv3_pkg.sv
design/conv3_dot.sv
design/conv2d_3x3_valid_stream_top.sv
test/testbench.sv
